@@ design/mgbd_pkg.sv @@
`timescale 1ns / 1ps

package mgbd_pkg;

    localparam int MaxGlyphWidth  = 256;
    localparam int MaxGlyphHeight = 256;

    localparam int DIM_W      = 9;   // width / height register
    localparam int BC_W       = 5;   // byte column, up to 32 bytes per row
    localparam int SR_W       = 8;   // source row
    localparam int BAND_W     = 3;   // row within a band
    localparam int SUM_W      = 7;   // column sum / gray level
    localparam int COL_W      = 6;
    localparam int ROW_W      = 6;
    localparam int SUM_ROWS   = 32;  // one row per byte column, two lanes each
    localparam int CFG_IDX_W  = 2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic [DIM_W-1:0] MAX_W_DIM = DIM_W'(MaxGlyphWidth);
    localparam logic [DIM_W-1:0] MAX_H_DIM = DIM_W'(MaxGlyphHeight);

    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_MODE   = 2'd2;

    typedef struct packed {
        logic                 valid;
        logic [CFG_IDX_W-1:0] index;
        logic [DIM_W-1:0]     data;
    } t_cfg_wr;

    // one classified byte, front to back
    typedef struct packed {
        logic [BC_W-1:0]  byte_col;
        logic [SUM_W-1:0] add0;
        logic [SUM_W-1:0] add1;
        logic             mode8;
        logic             end_band;
        logic             second;
        logic [ROW_W-1:0] out_row;
        logic             glyph_end;
    } t_work;

    function automatic logic [3:0] count8(input logic [7:0] b);
        logic [7:0] v;
        v = (b & 8'h55) + ((b & 8'haa) >> 1);
        v = (v & 8'h33) + ((v & 8'hcc) >> 2);
        v = (v & 8'h0f) + ((v & 8'hf0) >> 4);
        return v[3:0];
    endfunction

    function automatic logic [2:0] count4(input logic [3:0] n);
        logic [3:0] v;
        v = (n & 4'h5) + ((n & 4'ha) >> 1);
        v = (v & 4'h3) + ((v & 4'hc) >> 2);
        return v[2:0];
    endfunction

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > maxv) begin
            r = maxv;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

@@ design/mono_glyph_box_downsample.sv @@
`timescale 1ns / 1ps

// Box downsampler for 1-bit glyphs: takes one packed byte (MSB leftmost) per transfer in
// raster order and gives 0..64 gray pixels on each band's last row, one per byte in
// 8x8 mode, two per byte in 4x4 mode (one when the second column is past the reduced
// width). A byte is taken every cycle unless the queue is full; the output register moves
// one result per cycle when not stalled, so a 4x4 byte on a band's last row that yields two
// results holds the back end while it sends both, and a four-entry queue between classifier
// and accumulator absorbs that and output stalls. Column sums live in flip-flops with per-row
// valid bits, so there is no clearing pass after reset. The config port is always ready; any
// write restarts the glyph and must only be issued while the block is idle.
module mono_glyph_box_downsample (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mgbd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mgbd_pkg::DIM_W-1:0]        i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [7:0]                        i_pixel_bits,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [mgbd_pkg::SUM_W-1:0]        o_gray_level,
    output logic [mgbd_pkg::COL_W-1:0]        o_out_column,
    output logic [mgbd_pkg::ROW_W-1:0]        o_out_row,
    output logic                              o_last_of_item,
    output logic                              o_last_of_glyph
);
    import mgbd_pkg::*;

    t_cfg_wr cfg_wr;
    t_work   push_work;
    t_work   head_work;
    logic    push;
    logic    pop;
    logic    q_full;
    logic    head_valid;

    assign o_cfg_ready  = 1'b1;
    assign cfg_wr.valid = i_cfg_valid && o_cfg_ready;
    assign cfg_wr.index = i_cfg_index;
    assign cfg_wr.data  = i_cfg_data;

    mgbd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg_wr),
        .i_in_valid   (i_in_valid),
        .i_pixel_bits (i_pixel_bits),
        .i_q_full     (q_full),
        .o_in_stall   (o_in_stall),
        .o_push       (push),
        .o_work       (push_work)
    );

    mgbd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_work),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (head_valid),
        .o_head  (head_work)
    );

    mgbd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_clear         (cfg_wr.valid),
        .i_head_valid    (head_valid),
        .i_head          (head_work),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_gray_level    (o_gray_level),
        .o_out_column    (o_out_column),
        .o_out_row       (o_out_row),
        .o_last_of_item  (o_last_of_item),
        .o_last_of_glyph (o_last_of_glyph)
    );

endmodule

@@ design/mgbd_front.sv @@
`timescale 1ns / 1ps

module mgbd_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mgbd_pkg::t_cfg_wr     i_cfg,
    input  logic                  i_in_valid,
    input  logic [7:0]            i_pixel_bits,
    input  logic                  i_q_full,
    output logic                  o_in_stall,
    output logic                  o_push,
    output mgbd_pkg::t_work       o_work
);
    import mgbd_pkg::*;

    logic [DIM_W-1:0]  r_width;
    logic [DIM_W-1:0]  r_height;
    logic              r_mode;
    logic [BC_W-1:0]   r_byte_col;
    logic [SR_W-1:0]   r_src_row;
    logic [BAND_W-1:0] r_band_row;

    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [BC_W:0]    row_bytes;
    logic [6:0]       out_w;
    logic             last_col;
    logic             last_row;
    logic [3:0]       band_len;
    logic             end_band;
    logic [2:0]       frac;
    logic [7:0]       mask;
    logic [7:0]       b;
    logic [COL_W-1:0] c1;

    always_comb begin
        w         = clamp_dim(r_width, MAX_W_DIM);
        h         = clamp_dim(r_height, MAX_H_DIM);
        row_bytes = (BC_W+1)'(({1'b0, w} + 10'd7) >> 3);
        out_w     = 7'(({1'b0, w} + 10'd3) >> 2);
        last_col  = ((BC_W+1)'(r_byte_col) + (BC_W+1)'(1)) >= row_bytes;
        last_row  = (DIM_W'(r_src_row) + DIM_W'(1)) >= h;
        band_len  = r_mode ? 4'd8 : 4'd4;
        end_band  = ((4'(r_band_row) + 4'd1) >= band_len) || last_row;
        frac      = w[2:0];
        // clear pixels past the glyph's right edge
        mask      = (last_col && frac != 3'd0) ? 8'(8'hff << (4'd8 - 4'(frac))) : 8'hff;
        b         = i_pixel_bits & mask;
        c1        = {r_byte_col, 1'b1};

        o_work.byte_col  = r_byte_col;
        o_work.mode8     = r_mode;
        o_work.end_band  = end_band;
        o_work.second    = 7'(c1) < out_w;
        o_work.glyph_end = last_col && last_row;
        if (r_mode) begin
            o_work.add0    = SUM_W'(count8(b));
            o_work.add1    = '0;
            o_work.out_row = ROW_W'(r_src_row[SR_W-1:3]);
        end else begin
            o_work.add0    = SUM_W'({count4(b[7:4]), 2'b00});
            o_work.add1    = SUM_W'({count4(b[3:0]), 2'b00});
            o_work.out_row = r_src_row[SR_W-1:2];
        end
    end

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= DIM_W'(8);
            r_height   <= DIM_W'(8);
            r_mode     <= 1'b1;
            r_byte_col <= '0;
            r_src_row  <= '0;
            r_band_row <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_GLYPH_WIDTH:  r_width  <= i_cfg.data;
                CFG_GLYPH_HEIGHT: r_height <= i_cfg.data;
                CFG_SCALE_MODE:   r_mode   <= i_cfg.data[0];
                default:          ;
            endcase
            // any write restarts the glyph
            r_byte_col <= '0;
            r_src_row  <= '0;
            r_band_row <= '0;
        end else if (o_push) begin
            if (last_col) begin
                r_byte_col <= '0;
                if (last_row) begin
                    r_src_row  <= '0;
                    r_band_row <= '0;
                end else begin
                    r_src_row  <= r_src_row + SR_W'(1);
                    r_band_row <= end_band ? '0 : r_band_row + BAND_W'(1);
                end
            end else begin
                r_byte_col <= r_byte_col + BC_W'(1);
            end
        end
    end

endmodule

@@ design/mgbd_fifo.sv @@
`timescale 1ns / 1ps

module mgbd_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mgbd_pkg::t_work   i_data,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output mgbd_pkg::t_work   o_head
);
    import mgbd_pkg::*;

    t_work              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QPTR_W:0]    r_count;

    assign o_full  = r_count == (QPTR_W+1)'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (QPTR_W+1)'(1);
                2'b01:   r_count <= r_count - (QPTR_W+1)'(1);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ design/mgbd_back.sv @@
`timescale 1ns / 1ps

module mgbd_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clear,
    input  logic                          i_head_valid,
    input  mgbd_pkg::t_work               i_head,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [mgbd_pkg::SUM_W-1:0]    o_gray_level,
    output logic [mgbd_pkg::COL_W-1:0]    o_out_column,
    output logic [mgbd_pkg::ROW_W-1:0]    o_out_row,
    output logic                          o_last_of_item,
    output logic                          o_last_of_glyph
);
    import mgbd_pkg::*;

    // lane 0: even column (or the 8x8 column), lane 1: odd column in 4x4 mode
    logic [SUM_W-1:0]    r_sum_lo [SUM_ROWS];
    logic [SUM_W-1:0]    r_sum_hi [SUM_ROWS];
    logic [SUM_ROWS-1:0] r_row_valid;
    logic                r_phase;   // second result of a 4x4 byte pending

    logic                r_out_valid;
    logic [SUM_W-1:0]    r_gray;
    logic [COL_W-1:0]    r_col;
    logic [ROW_W-1:0]    r_row;
    logic                r_last_item;
    logic                r_last_glyph;

    logic             out_free;
    logic             two;
    logic             emit;
    logic [SUM_W-1:0] s0;
    logic [SUM_W-1:0] s1;
    logic [SUM_W-1:0] n_gray;
    logic [COL_W-1:0] n_col;
    logic             n_last_item;
    logic             n_last_glyph;

    always_comb begin
        out_free = !r_out_valid || !i_out_stall;
        two      = !i_head.mode8 && i_head.second;
        s0 = (r_row_valid[i_head.byte_col] ? r_sum_lo[i_head.byte_col] : '0) + i_head.add0;
        s1 = (r_row_valid[i_head.byte_col] ? r_sum_hi[i_head.byte_col] : '0) + i_head.add1;
        emit  = i_head_valid && i_head.end_band && out_free;
        o_pop = i_head_valid && (!i_head.end_band || (out_free && (!two || r_phase)));

        if (r_phase) begin
            n_gray       = s1;
            n_col        = {i_head.byte_col, 1'b1};
            n_last_item  = 1'b1;
            n_last_glyph = i_head.glyph_end;
        end else begin
            n_gray       = s0;
            n_col        = i_head.mode8 ? {1'b0, i_head.byte_col} : {i_head.byte_col, 1'b0};
            n_last_item  = !two;
            n_last_glyph = i_head.glyph_end && !two;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
            r_row_valid <= '0;
        end else if (i_clear) begin
            r_phase     <= 1'b0;
            r_row_valid <= '0;
        end else begin
            if (emit) begin
                r_phase     <= two && !r_phase;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                r_row_valid[i_head.byte_col] <= !i_head.end_band;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && !i_head.end_band) begin
            r_sum_lo[i_head.byte_col] <= s0;
            r_sum_hi[i_head.byte_col] <= s1;
        end
        if (emit) begin
            r_gray       <= n_gray;
            r_col        <= n_col;
            r_row        <= i_head.out_row;
            r_last_item  <= n_last_item;
            r_last_glyph <= n_last_glyph;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_gray_level    = r_gray;
    assign o_out_column    = r_col;
    assign o_out_row       = r_row;
    assign o_last_of_item  = r_last_item;
    assign o_last_of_glyph = r_last_glyph;

`ifndef SYNTHESIS
    a_phase_has_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (i_head_valid && !i_head.mode8 && i_head.end_band && i_head.second))
        else $error("second-result phase without a matching 4x4 byte");

    a_glyph_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_last_glyph || r_last_item))
        else $error("glyph end on a result that does not end its byte");

    a_first_then_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && !r_phase && two && !i_clear) |=> r_phase)
        else $error("4x4 byte lost its second result");

    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_clear |-> !r_phase)
        else $error("configuration write while a byte is in flight");
`endif

endmodule
